// ===== src/hbd_pkg.sv =====
`default_nettype none

package hbd_pkg;

  localparam int MAX_NODES = 2048;
  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W = NODE_W + 1;
  localparam int SYM_W = 16;
  localparam int PAY_W = 16;
  localparam int ENT_W = PAY_W + 2;
  localparam int ROW_W = 2 * ENT_W;
  localparam int MAX_CODE_BITS = 32;
  localparam int CODE_W = 32;
  localparam int LEN_W = 6;
  localparam int IDX_W = $clog2(MAX_CODE_BITS);
  localparam int WORD_W = 64;
  localparam int WBITS_W = 7;
  localparam int BIT_IDX_W = $clog2(WORD_W);
  localparam int STATUS_W = 3;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_DECODE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_SYMBOL  = 3'd0,
    ST_ADDED   = 3'd1,
    ST_COLLIDE = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_EVAL,
    S_ADD_ALLOC,
    S_DEC_RD,
    S_DEC_EVAL,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic    clear;
    logic    load_add;
    logic    load_dec;
    logic    rd_walk;
    logic    add_step;
    logic    add_link;
    logic    add_alloc;
    logic    add_leaf;
    logic    dec_step;
    logic    push;
    status_t push_status;
    logic    flush;
  } cmd_t;

  typedef struct packed {
    logic ent_used;
    logic ent_leaf;
    logic final_bit;
    logic tree_full;
    logic bits_zero;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/hbd_ctrl.sv =====
`default_nettype none

module hbd_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [1:0]   operation,
  input  wire hbd_pkg::stat_t stat,
  output hbd_pkg::cmd_t     cmd,
  output logic              busy
);
  import hbd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (operation)
            OP_ADD: state_next = S_ADD_RD;
            OP_DECODE: begin
              if (!stat.bits_zero) begin
                state_next = S_DEC_RD;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ADD_RD: state_next = S_ADD_EVAL;
      S_ADD_EVAL: begin
        if (stat.final_bit) begin
          state_next = S_FLUSH;
        end else if (!stat.ent_used) begin
          state_next = stat.tree_full ? S_FLUSH : S_ADD_ALLOC;
        end else if (stat.ent_leaf) begin
          state_next = S_FLUSH;
        end else begin
          state_next = S_ADD_RD;
        end
      end
      S_ADD_ALLOC: state_next = S_ADD_RD;
      S_DEC_RD: state_next = S_DEC_EVAL;
      S_DEC_EVAL: begin
        if (!stat.ent_used || stat.final_bit) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.push_status = ST_SYMBOL;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          case (operation)
            OP_CLEAR: cmd.clear = 1'b1;
            OP_ADD: cmd.load_add = 1'b1;
            OP_DECODE: cmd.load_dec = 1'b1;
            default: cmd.clear = 1'b0;
          endcase
        end
      end
      S_ADD_EVAL: begin
        if (stat.final_bit) begin
          cmd.push = 1'b1;
          if (stat.ent_used) begin
            cmd.push_status = ST_COLLIDE;
          end else begin
            cmd.add_leaf = 1'b1;
            cmd.push_status = ST_ADDED;
          end
        end else if (!stat.ent_used) begin
          if (stat.tree_full) begin
            cmd.push = 1'b1;
            cmd.push_status = ST_FULL;
          end else begin
            cmd.add_link = 1'b1;
          end
        end else if (stat.ent_leaf) begin
          cmd.push = 1'b1;
          cmd.push_status = ST_COLLIDE;
        end else begin
          cmd.add_step = 1'b1;
        end
      end
      S_ADD_ALLOC: cmd.add_alloc = 1'b1;
      S_DEC_RD: cmd.rd_walk = 1'b1;
      S_DEC_EVAL: begin
        cmd.dec_step = 1'b1;
        if (!stat.ent_used) begin
          cmd.push = 1'b1;
          cmd.push_status = ST_EMPTY;
        end else if (stat.ent_leaf) begin
          cmd.push = 1'b1;
          cmd.push_status = ST_SYMBOL;
        end
      end
      S_FLUSH: cmd.flush = 1'b1;
      default: cmd.flush = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/hbd_dpath.sv =====
`default_nettype none

module hbd_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire hbd_pkg::cmd_t                   cmd,
  input  wire logic [hbd_pkg::SYM_W-1:0]       symbol_value,
  input  wire logic [hbd_pkg::CODE_W-1:0]      code_bits,
  input  wire logic [hbd_pkg::LEN_W-1:0]       code_length,
  input  wire logic [hbd_pkg::WORD_W-1:0]      data_word,
  input  wire logic [hbd_pkg::WBITS_W-1:0]     word_bits,
  input  wire logic                            stream_start,
  output hbd_pkg::stat_t                       stat,
  output logic                                 result_valid,
  output logic [hbd_pkg::SYM_W-1:0]            symbol_value_out,
  output logic [hbd_pkg::STATUS_W-1:0]         status,
  output logic                                 last
);
  import hbd_pkg::*;

  logic [ROW_W-1:0] mem [MAX_NODES];
  logic [ROW_W-1:0] row_q;
  logic             rd_root;
  logic             root_valid;

  logic [CNT_W-1:0]     nodes_used;
  logic [NODE_W-1:0]    walk;
  logic [NODE_W-1:0]    curr;
  logic [CODE_W-1:0]    code;
  logic [LEN_W-1:0]     add_len;
  logic [IDX_W-1:0]     add_idx;
  logic [SYM_W-1:0]     add_sym;
  logic [WORD_W-1:0]    word;
  logic [WBITS_W-1:0]   dec_bits;
  logic [BIT_IDX_W-1:0] dec_idx;
  logic                 dec_mode;

  logic                 pend_valid;
  logic [SYM_W-1:0]     pend_sym;
  status_t              pend_status;

  logic [ROW_W-1:0]  row_eff;
  logic              sel_bit;
  logic [ENT_W-1:0]  entry;
  logic [PAY_W-1:0]  payload;
  logic [NODE_W-1:0] walk_next;
  logic [NODE_W-1:0] raddr;
  logic              we;
  logic [ENT_W-1:0]  new_ent;
  logic [ROW_W-1:0]  wdata;
  logic [SYM_W-1:0]  push_sym;
  logic              emit;
  logic              emit_last;

  // The root pair reads as empty until it is first written after a reset or a clear.
  assign row_eff = (rd_root && !root_valid) ? '0 : row_q;
  assign sel_bit = dec_mode ? word[0] : code[0];
  assign entry = sel_bit ? row_eff[ROW_W-1:ENT_W] : row_eff[ENT_W-1:0];
  assign payload = entry[PAY_W-1:0];

  assign stat.ent_used = entry[ENT_W-1];
  assign stat.ent_leaf = entry[ENT_W-2];
  assign stat.final_bit = dec_mode ? ((WBITS_W'(dec_idx) + WBITS_W'(1)) == dec_bits)
                                   : ((LEN_W'(add_idx) + LEN_W'(1)) == add_len);
  assign stat.tree_full = (nodes_used == CNT_W'(MAX_NODES));
  assign stat.bits_zero = (word_bits == '0);

  assign walk_next = (!entry[ENT_W-1] || entry[ENT_W-2]) ? '0 : payload[NODE_W-1:0];

  always_comb begin
    if (cmd.dec_step) begin
      raddr = walk_next;
    end else if (cmd.rd_walk) begin
      raddr = walk;
    end else begin
      raddr = curr;
    end
  end

  assign we = cmd.add_link || cmd.add_leaf || cmd.add_alloc;

  always_comb begin
    if (cmd.add_leaf) begin
      new_ent = {1'b1, 1'b1, PAY_W'(add_sym)};
    end else begin
      new_ent = {1'b1, 1'b0, PAY_W'(nodes_used[NODE_W-1:0])};
    end
    if (cmd.add_alloc) begin
      wdata = '0;
    end else if (sel_bit) begin
      wdata = {new_ent, row_eff[ENT_W-1:0]};
    end else begin
      wdata = {row_eff[ROW_W-1:ENT_W], new_ent};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[curr] <= wdata;
    end
    row_q <= mem[raddr];
    rd_root <= (raddr == '0);
  end

  assign push_sym = (cmd.push_status == ST_SYMBOL) ? payload[SYM_W-1:0] : '0;
  assign emit = (cmd.push || cmd.flush) && pend_valid;
  assign emit_last = cmd.flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_valid <= 1'b0;
      nodes_used <= CNT_W'(1);
      walk <= '0;
      pend_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
      if (cmd.clear) begin
        root_valid <= 1'b0;
        nodes_used <= CNT_W'(1);
        walk <= '0;
      end else begin
        if (we && (curr == '0)) begin
          root_valid <= 1'b1;
        end
        if (cmd.add_link) begin
          nodes_used <= nodes_used + CNT_W'(1);
        end
        if (cmd.load_dec && stream_start) begin
          walk <= '0;
        end else if (cmd.dec_step) begin
          walk <= walk_next;
        end
      end
      if (cmd.push) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_add) begin
      dec_mode <= 1'b0;
      curr <= '0;
      add_idx <= '0;
      code <= code_bits;
      add_sym <= symbol_value;
      if (code_length == '0) begin
        add_len <= LEN_W'(1);
      end else if (code_length > LEN_W'(MAX_CODE_BITS)) begin
        add_len <= LEN_W'(MAX_CODE_BITS);
      end else begin
        add_len <= code_length;
      end
    end else if (cmd.add_step) begin
      curr <= payload[NODE_W-1:0];
      add_idx <= add_idx + IDX_W'(1);
      code <= code >> 1;
    end else if (cmd.add_link) begin
      curr <= nodes_used[NODE_W-1:0];
    end else if (cmd.add_alloc) begin
      add_idx <= add_idx + IDX_W'(1);
      code <= code >> 1;
    end
    if (cmd.load_dec) begin
      dec_mode <= 1'b1;
      word <= data_word;
      dec_idx <= '0;
      if (word_bits > WBITS_W'(WORD_W)) begin
        dec_bits <= WBITS_W'(WORD_W);
      end else begin
        dec_bits <= word_bits;
      end
    end else if (cmd.dec_step) begin
      word <= word >> 1;
      dec_idx <= dec_idx + BIT_IDX_W'(1);
    end
    if (cmd.push) begin
      pend_sym <= push_sym;
      pend_status <= cmd.push_status;
    end
    if (emit) begin
      symbol_value_out <= pend_sym;
      status <= pend_status;
      last <= emit_last;
    end
  end

endmodule

`default_nettype wire

// ===== src/huffman_tree_bit_decoder.sv =====
// Huffman decoder that keeps its binary code tree in an on-chip node memory.
// Commands are transferred by raising start while busy is low; operation
// selects clear tree, add code or decode word. A clear takes effect in the
// transfer cycle and gives no result. An add code walks its path one code bit
// at a time, reading a tree row and then evaluating it, with an extra
// allocation step for each new node, and gives one result (code added, code
// collision or tree full) with last set. A decode first reads the current
// tree row, then takes one data bit per cycle, since the next row is read from
// the single read port while the current bit is evaluated, then flushes. Each
// symbol reached gives one result; an empty branch gives a final result and
// drops the rest of the word. The walk position carries over between words
// unless stream_start is set. Each result is held until the next result of
// the same command is found or the command ends, and then shows on
// result_valid for one cycle; the last of each command carries last. The
// receiver cannot stall. Reset empties the tree, frees all nodes and
// returns the walk to the root, with no clearing pass.
`default_nettype none

module huffman_tree_bit_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      operation,
  input  wire logic [hbd_pkg::SYM_W-1:0]       symbol_value,
  input  wire logic [hbd_pkg::CODE_W-1:0]      code_bits,
  input  wire logic [hbd_pkg::LEN_W-1:0]       code_length,
  input  wire logic [hbd_pkg::WORD_W-1:0]      data_word,
  input  wire logic [hbd_pkg::WBITS_W-1:0]     word_bits,
  input  wire logic                            stream_start,
  output logic                                 result_valid,
  output logic [hbd_pkg::SYM_W-1:0]            symbol_value_out,
  output logic [hbd_pkg::STATUS_W-1:0]         status,
  output logic                                 last
);
  import hbd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  hbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  hbd_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .symbol_value     (symbol_value),
    .code_bits        (code_bits),
    .code_length      (code_length),
    .data_word        (data_word),
    .word_bits        (word_bits),
    .stream_start     (stream_start),
    .stat             (stat),
    .result_valid     (result_valid),
    .symbol_value_out (symbol_value_out),
    .status           (status),
    .last             (last)
  );

endmodule

`default_nettype wire

// ===== src/hbd_checker.sv =====
`default_nettype none

module hbd_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic [1:0]                  operation,
  input wire logic                        result_valid,
  input wire logic [hbd_pkg::SYM_W-1:0]   symbol_value_out,
  input wire logic [hbd_pkg::STATUS_W-1:0] status,
  input wire logic                        last
);
  import hbd_pkg::*;

  a_add_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_ADD) |=> busy)
    else $error("add code transfer did not start a walk");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_CLEAR) |=> (!busy && !result_valid))
    else $error("clear produced activity");

  a_add_result_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status == ST_ADDED || status == ST_COLLIDE || status == ST_FULL))
      |-> (last && symbol_value_out == '0))
    else $error("add result not final or carries a symbol");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == ST_EMPTY) |-> (last && symbol_value_out == '0))
    else $error("empty branch result not final");

endmodule

bind huffman_tree_bit_decoder hbd_checker u_hbd_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .operation        (operation),
  .result_valid     (result_valid),
  .symbol_value_out (symbol_value_out),
  .status           (status),
  .last             (last)
);

`default_nettype wire
